[sv/rs_pkg.sv]
// rs_pkg: shared constants, codes and cell control types for the recency stack
// used by rs_cell and recency_stack; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rs_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_MOVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_BOTTOM = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // what every cell does with its slot
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_DELETE,
        CMD_MOVE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [DATA_W-1:0]  key;
    } cell_cmd_t;

endpackage

`default_nettype wire

[sv/rs_cell.sv]
// rs_cell: one slot of the recency stack, compares against the key and
// shifts toward a neighbor; depends on rs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rs_cell
    import rs_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_cmd_t         cmd,
    input  wire logic              slot_valid,
    input  wire logic [DATA_W-1:0] up_val,
    input  wire logic [DATA_W-1:0] down_val,
    input  wire logic              found_in,
    output logic [DATA_W-1:0]      val,
    output logic                   found_out
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              match;

    assign match     = slot_valid && (val_reg == cmd.key);
    assign found_out = found_in || match;
    assign val       = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (cmd.kind)
            CMD_PUSH:   val_next = up_val;
            CMD_POP:    val_next = down_val;
            // slots at and below the topmost match close the gap
            CMD_DELETE:
            begin
                if (found_out)
                    val_next = down_val;
            end
            // slots down to the topmost match shift down, the rest hold
            CMD_MOVE:
            begin
                if (!found_in)
                    val_next = up_val;
            end
            default:    val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

[sv/recency_stack.sv]
// recency_stack: top level, a chain of rs_cell slots with the fill count and
// a registered result stage; depends on rs_pkg and rs_cell
`timescale 1ns / 1ps
`default_nettype none

// Bounded recency stack of DEPTH unsigned 32-bit values, slot 0 on top. Push,
// pop, delete and move to top are done by the row of cells: each slot
// compares itself with the key and takes its upper or lower neighbor's value,
// with the topmost match found along the chain; remove bottom only lowers the
// fill count. One transfer is accepted per cycle while the result register
// is free or being taken; a held result stalls the input. Results appear in
// the cycle after their transfer, in order, one per operation.
module recency_stack
    import rs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [DATA_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [DATA_W-1:0]      removed_value,
    output logic [FILL_W-1:0]      fill_level
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [DATA_W-1:0] removed_reg;
    logic [DATA_W-1:0] removed_next;

    logic              accept;
    logic              empty;
    logic              full;
    logic              found_any;
    logic [DATA_W-1:0] bottom_val;
    cell_cmd_t         cmd;

    logic [DATA_W-1:0] vals  [DEPTH];
    logic [DEPTH:0]    found;
    logic [DEPTH-1:0]  valid;
    logic [DEPTH-1:0]  bottom_sel;

    assign in_stall      = out_valid_reg && out_stall;
    assign accept        = in_valid && !in_stall;
    assign empty         = (count_reg == '0);
    assign full          = (count_reg == CNT_W'(DEPTH));
    assign found[0]      = 1'b0;
    assign found_any     = found[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] up_v;
            logic [DATA_W-1:0] down_v;

            assign valid[gi]      = (CNT_W'(gi) < count_reg);
            assign bottom_sel[gi] = (CNT_W'(gi + 1) == count_reg);

            if (gi == 0)
            begin : g_top
                assign up_v = value;
            end
            else
            begin : g_mid
                assign up_v = vals[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign down_v = vals[gi];
            end
            else
            begin : g_inner
                assign down_v = vals[gi+1];
            end

            rs_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .slot_valid (valid[gi]),
                .up_val     (up_v),
                .down_val   (down_v),
                .found_in   (found[gi]),
                .val        (vals[gi]),
                .found_out  (found[gi+1])
            );
        end
    endgenerate

    // bottom slot is one-hot selected from the fill count
    always_comb
    begin
        bottom_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (bottom_sel[i])
                bottom_val = bottom_val | vals[i];
        end
    end

    always_comb
    begin
        cmd.key      = value;
        cmd.kind     = CMD_HOLD;
        count_next   = count_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            removed_next   = '0;
            case (operation)
                OP_PUSH:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.kind   = CMD_PUSH;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        cmd.kind     = CMD_POP;
                        removed_next = vals[0];
                        count_next   = count_reg - 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (!found_any)
                        status_next = ST_NOT_FOUND;
                    else
                    begin
                        cmd.kind     = CMD_DELETE;
                        removed_next = value;
                        count_next   = count_reg - 1'b1;
                    end
                end
                OP_MOVE:
                begin
                    if (found_any)
                        cmd.kind = CMD_MOVE;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.kind   = CMD_PUSH;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_BOTTOM:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        removed_next = bottom_val;
                        count_next   = count_reg - 1'b1;
                    end
                end
                default: status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign fill_level    = FILL_W'(count_reg);

`ifndef SYNTH
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_full_push : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_PUSH && full) |=>
            (status_reg == ST_FULL && count_reg == $past(count_reg)))
        else $error("push into full stack not refused");

    a_move_count : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_MOVE && found_any) |=>
            (count_reg == $past(count_reg) && status_reg == ST_OK))
        else $error("move to top with match changed fill count");

    a_delete_hit : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_DELETE && found_any) |=>
            (count_reg == $past(count_reg) - 1'b1 && removed_reg == $past(value)))
        else $error("delete with match did not remove one entry");
`endif

endmodule

`default_nettype wire
